FILE: rtl/rcta_pkg.sv
package rcta_pkg;

    // fixed formats
    localparam int SKY_SIZE        = 512;
    localparam int BYTES_PER_PIXEL = 4;
    localparam int SKY_BITS        = $clog2(SKY_SIZE);
    localparam int BPP_SHIFT       = $clog2(BYTES_PER_PIXEL);

    localparam int POS_W     = 12;
    localparam int LINE_W    = 16;
    localparam int HIT_W     = 24;
    localparam int SCREEN_W  = 13;
    localparam int TEX_DIM_W = 11;
    localparam int COLOR_W   = 24;
    localparam int ID_W      = 3;
    localparam int TEXEL_W   = 22;
    localparam int FRAME_W   = 26;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // texel row arithmetic: span term 2*row - height + line, its magnitude,
    // the 2*line divisor, the texture height product and the row quotient
    localparam int DSPAN_W = LINE_W + 3;
    localparam int NUM_W   = LINE_W + 1;
    localparam int DIV_W   = LINE_W + 1;
    localparam int PROD_W  = TEX_DIM_W + DIV_W;
    localparam int QUO_W   = TEX_DIM_W;
    localparam int TPROD_W = 8 + TEX_DIM_W;

    // reset values of the registers
    localparam logic [SCREEN_W-1:0]  SCREEN_WIDTH_RST  = 13'd640;
    localparam logic [SCREEN_W-1:0]  SCREEN_HEIGHT_RST = 13'd480;
    localparam logic [TEX_DIM_W-1:0] TEX_WIDTH_RST     = 11'd64;
    localparam logic [TEX_DIM_W-1:0] TEX_HEIGHT_RST    = 11'd64;
    localparam logic [COLOR_W-1:0]   FLOOR_COLOR_RST   = 24'd293994;

    // texture slots
    localparam logic [ID_W-1:0] TEX_ID_Y_NEG = 3'd0;
    localparam logic [ID_W-1:0] TEX_ID_SKY   = 3'd1;
    localparam logic [ID_W-1:0] TEX_ID_X_POS = 3'd2;
    localparam logic [ID_W-1:0] TEX_ID_X_NEG = 3'd3;
    localparam logic [ID_W-1:0] TEX_ID_Y_POS = 3'd4;
    localparam logic [ID_W-1:0] TEX_ID_NONE  = 3'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCREEN_WIDTH  = 3'd0,
        CFG_SCREEN_HEIGHT = 3'd1,
        CFG_TEX_WIDTH     = 3'd2,
        CFG_TEX_HEIGHT    = 3'd3,
        CFG_FLOOR_COLOR   = 3'd4
    } t_cfg_reg;

    typedef enum logic [1:0] {
        SRC_SKY   = 2'd0,
        SRC_WALL  = 2'd1,
        SRC_FLOOR = 2'd2
    } t_source;

    typedef struct packed {
        logic [POS_W-1:0]        column;
        logic [POS_W-1:0]        row;
        logic [POS_W-1:0]        span_start;
        logic [POS_W-1:0]        span_end;
        logic [LINE_W-1:0]       line_height;
        logic                    hit_side;
        logic                    ray_x_positive;
        logic                    ray_y_negative;
        logic signed [HIT_W-1:0] wall_hit;
    } t_in;

    typedef struct packed {
        t_source              pixel_source;
        logic [ID_W-1:0]      texture_id;
        logic [TEXEL_W-1:0]   texel_offset;
        logic [FRAME_W-1:0]   frame_offset;
        logic [COLOR_W-1:0]   fill_color;
    } t_out;

    // everything one pixel carries down the pipeline
    typedef struct packed {
        t_source              source;
        logic [ID_W-1:0]      id;
        logic [POS_W-1:0]     col;
        logic [FRAME_W-1:0]   frame;
        logic [TEXEL_W-1:0]   texel;
        logic [PROD_W-1:0]    dvd;
        logic [DIV_W-1:0]     rem;
        logic [DIV_W-1:0]     m;
        logic [QUO_W-1:0]     quo;
        logic [TEX_DIM_W-1:0] tcol;
    } t_stage;

endpackage

FILE: rtl/raycast_column_texel_address.sv
// channel  direction  handshake                  payload
// in       input      i_in_valid / o_in_ready    i_in_data   (rcta_pkg::t_in)
// out      output     o_out_valid / i_out_ready  o_out_data  (rcta_pkg::t_out)
// cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one pixel per clock unless the skid buffer is full; the texel row comes from the
// two one-bit-per-stage restoring dividers (17 + 11 stages)
// off-screen pixels ride along as bubbles and give no output beat
// synchronous active-low reset clears all valid bits and loads register defaults
// a one-beat skid buffer holds a stalled result; the pipeline freezes only
// while it is full, so an output stall loses and repeats nothing
module raycast_column_texel_address (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  rcta_pkg::t_in                       i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output rcta_pkg::t_out                      o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rcta_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rcta_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // stage map
    localparam int S_DEC      = 1;
    localparam int DIV1_FIRST = S_DEC + 1;
    localparam int DIV1_LAST  = DIV1_FIRST + rcta_pkg::NUM_W - 1;
    localparam int S_MUL      = DIV1_LAST + 1;
    localparam int DIV2_FIRST = S_MUL + 1;
    localparam int DIV2_LAST  = DIV2_FIRST + rcta_pkg::QUO_W - 1;
    localparam int S_TPROD    = DIV2_LAST + 1;
    localparam int S_OUT      = S_TPROD + 1;

    // configuration registers
    logic [rcta_pkg::SCREEN_W-1:0]  r_screen_width;
    logic [rcta_pkg::SCREEN_W-1:0]  r_screen_height;
    logic [rcta_pkg::TEX_DIM_W-1:0] r_tex_width;
    logic [rcta_pkg::TEX_DIM_W-1:0] r_tex_height;
    logic [rcta_pkg::COLOR_W-1:0]   r_floor_color;

    // pipeline
    logic                           w_en;
    rcta_pkg::t_in                  r_in;
    logic [S_OUT:0]                 r_vld;
    logic [S_OUT:0]                 n_vld;
    rcta_pkg::t_stage               r_st [S_DEC:S_OUT];
    rcta_pkg::t_stage               n_st [S_DEC:S_OUT];
    rcta_pkg::t_stage               n_dec;
    logic                           w_on_screen;

    // decode temporaries
    logic [rcta_pkg::LINE_W-1:0]    w_lh;
    logic [rcta_pkg::DSPAN_W-1:0]   w_dspan;
    logic [rcta_pkg::DSPAN_W-1:0]   w_dmag;
    logic [rcta_pkg::HIT_W-1:0]     w_hit_mag;
    logic [rcta_pkg::TPROD_W-1:0]   w_tcol_prod;
    logic [2*rcta_pkg::SKY_BITS+rcta_pkg::BPP_SHIFT-1:0] w_sky_full;

    // output side
    rcta_pkg::t_out                 w_last;
    rcta_pkg::t_out                 r_skid;
    logic                           r_skid_vld;

    // config write port, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= rcta_pkg::SCREEN_WIDTH_RST;
            r_screen_height <= rcta_pkg::SCREEN_HEIGHT_RST;
            r_tex_width     <= rcta_pkg::TEX_WIDTH_RST;
            r_tex_height    <= rcta_pkg::TEX_HEIGHT_RST;
            r_floor_color   <= rcta_pkg::FLOOR_COLOR_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rcta_pkg::CFG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_data[rcta_pkg::SCREEN_W-1:0];
                rcta_pkg::CFG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data[rcta_pkg::SCREEN_W-1:0];
                rcta_pkg::CFG_TEX_WIDTH:     r_tex_width     <= i_cfg_data[rcta_pkg::TEX_DIM_W-1:0];
                rcta_pkg::CFG_TEX_HEIGHT:    r_tex_height    <= i_cfg_data[rcta_pkg::TEX_DIM_W-1:0];
                rcta_pkg::CFG_FLOOR_COLOR:   r_floor_color   <= i_cfg_data[rcta_pkg::COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline moves whenever the skid buffer is empty
    assign w_en       = !r_skid_vld;
    assign o_in_ready = w_en;

    // decode stage: region, texture slot, sky texel, frame row, texel column, divider operands
    always_comb begin
        w_on_screen = ({1'b0, r_in.column} < r_screen_width) &&
                      ({1'b0, r_in.row} < r_screen_height);
        w_lh = (r_in.line_height == '0) ? rcta_pkg::LINE_W'(1) : r_in.line_height;
        w_dspan = rcta_pkg::DSPAN_W'({r_in.row, 1'b0}) + rcta_pkg::DSPAN_W'(w_lh)
                - rcta_pkg::DSPAN_W'(r_screen_height);
        w_dmag = w_dspan[rcta_pkg::DSPAN_W-1] ? (~w_dspan + rcta_pkg::DSPAN_W'(1)) : w_dspan;
        w_hit_mag = r_in.wall_hit[rcta_pkg::HIT_W-1]
                  ? (~r_in.wall_hit + rcta_pkg::HIT_W'(1)) : r_in.wall_hit;
        // integer part of the hit drops out of the modulo, only the fraction matters
        w_tcol_prod = rcta_pkg::TPROD_W'(w_hit_mag[7:0]) * rcta_pkg::TPROD_W'(r_tex_width);
        w_sky_full = {r_in.row[rcta_pkg::SKY_BITS-1:0], r_in.column[rcta_pkg::SKY_BITS-1:0],
                      rcta_pkg::BPP_SHIFT'(0)};

        n_dec       = '0;
        n_dec.col   = r_in.column;
        n_dec.frame = rcta_pkg::FRAME_W'(r_in.row) * rcta_pkg::FRAME_W'(r_screen_width);
        n_dec.dvd   = rcta_pkg::PROD_W'(w_dmag[rcta_pkg::NUM_W-1:0]);
        n_dec.m     = {w_lh, 1'b0};
        n_dec.tcol  = w_tcol_prod[rcta_pkg::TPROD_W-1:8];
        if (r_in.row < r_in.span_start) begin
            n_dec.source = rcta_pkg::SRC_SKY;
            n_dec.id     = rcta_pkg::TEX_ID_SKY;
            n_dec.texel  = rcta_pkg::TEXEL_W'(w_sky_full);
        end else if (r_in.row <= r_in.span_end) begin
            n_dec.source = rcta_pkg::SRC_WALL;
            if (!r_in.hit_side) begin
                n_dec.id = r_in.ray_x_positive ? rcta_pkg::TEX_ID_X_POS : rcta_pkg::TEX_ID_X_NEG;
            end else begin
                n_dec.id = r_in.ray_y_negative ? rcta_pkg::TEX_ID_Y_NEG : rcta_pkg::TEX_ID_Y_POS;
            end
        end else begin
            n_dec.source = rcta_pkg::SRC_FLOOR;
            n_dec.id     = rcta_pkg::TEX_ID_NONE;
        end
    end

    // remaining stages: two restoring dividers, products and final add
    always_comb begin
        logic [rcta_pkg::DIV_W:0] shifted;
        logic                     ge;
        logic [rcta_pkg::PROD_W-1:0] prod;

        n_vld    = {r_vld[S_OUT-1:S_DEC], r_vld[0] & w_on_screen, i_in_valid};
        n_st[S_DEC] = n_dec;

        // |span term| mod 2*line, one bit per stage
        for (int k = DIV1_FIRST; k <= DIV1_LAST; k++) begin
            n_st[k]     = r_st[k-1];
            shifted     = {r_st[k-1].rem, r_st[k-1].dvd[rcta_pkg::NUM_W-1]};
            ge          = shifted >= {1'b0, r_st[k-1].m};
            n_st[k].rem = ge ? rcta_pkg::DIV_W'(shifted - {1'b0, r_st[k-1].m})
                             : shifted[rcta_pkg::DIV_W-1:0];
            n_st[k].dvd = r_st[k-1].dvd << 1;
        end

        // texture height times remainder; frame offset add
        n_st[S_MUL]       = r_st[DIV1_LAST];
        prod              = rcta_pkg::PROD_W'(r_st[DIV1_LAST].rem)
                          * rcta_pkg::PROD_W'(r_tex_height);
        n_st[S_MUL].dvd   = rcta_pkg::PROD_W'(prod[rcta_pkg::QUO_W-1:0]);
        n_st[S_MUL].rem   = prod[rcta_pkg::PROD_W-1:rcta_pkg::QUO_W];
        n_st[S_MUL].frame = (r_st[DIV1_LAST].frame + rcta_pkg::FRAME_W'(r_st[DIV1_LAST].col))
                          << rcta_pkg::BPP_SHIFT;

        // texel row quotient, already below the texture height
        for (int k = DIV2_FIRST; k <= DIV2_LAST; k++) begin
            n_st[k]     = r_st[k-1];
            shifted     = {r_st[k-1].rem, r_st[k-1].dvd[rcta_pkg::QUO_W-1]};
            ge          = shifted >= {1'b0, r_st[k-1].m};
            n_st[k].rem = ge ? rcta_pkg::DIV_W'(shifted - {1'b0, r_st[k-1].m})
                             : shifted[rcta_pkg::DIV_W-1:0];
            n_st[k].dvd = r_st[k-1].dvd << 1;
            n_st[k].quo = {r_st[k-1].quo[rcta_pkg::QUO_W-2:0], ge};
        end

        // row times texture width
        n_st[S_TPROD] = r_st[DIV2_LAST];
        if (r_st[DIV2_LAST].source == rcta_pkg::SRC_WALL) begin
            n_st[S_TPROD].texel = rcta_pkg::TEXEL_W'(r_st[DIV2_LAST].quo)
                                * rcta_pkg::TEXEL_W'(r_tex_width);
        end

        // add texel column and scale to bytes
        n_st[S_OUT] = r_st[S_TPROD];
        if (r_st[S_TPROD].source == rcta_pkg::SRC_WALL) begin
            n_st[S_OUT].texel = (r_st[S_TPROD].texel + rcta_pkg::TEXEL_W'(r_st[S_TPROD].tcol))
                              << rcta_pkg::BPP_SHIFT;
        end
    end

    // pipeline registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in <= i_in_data;
            for (int k = S_DEC; k <= S_OUT; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    // result beat from the last stage
    always_comb begin
        w_last.pixel_source = r_st[S_OUT].source;
        w_last.texture_id   = r_st[S_OUT].id;
        w_last.texel_offset = r_st[S_OUT].texel;
        w_last.frame_offset = r_st[S_OUT].frame;
        w_last.fill_color   = (r_st[S_OUT].source == rcta_pkg::SRC_FLOOR) ? r_floor_color : '0;
    end

    // skid buffer catches the last stage when the consumer stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (i_out_ready) begin
                r_skid_vld <= 1'b0;
            end
        end else if (r_vld[S_OUT] && !i_out_ready) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_vld && r_vld[S_OUT] && !i_out_ready) begin
            r_skid <= w_last;
        end
    end

    assign o_out_valid = r_skid_vld || r_vld[S_OUT];
    assign o_out_data  = r_skid_vld ? r_skid : w_last;

`ifndef NO_ASSERTIONS
    // a held result keeps its value until taken
    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld && !i_out_ready |=> r_skid_vld && $stable(r_skid))
        else $error("skid buffer changed while stalled");

    // first divider leaves a remainder below its divisor
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[DIV1_LAST] |-> r_st[DIV1_LAST].rem < r_st[DIV1_LAST].m)
        else $error("texel row remainder out of range");

    // texel row stays below the texture height
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[DIV2_LAST] && r_st[DIV2_LAST].source == rcta_pkg::SRC_WALL
            && r_tex_height != '0
        |-> rcta_pkg::TEX_DIM_W'(r_st[DIV2_LAST].quo) < r_tex_height)
        else $error("texel row not below texture height");

    // wall beats carry one of the four wall slots
    a_wall_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.pixel_source == rcta_pkg::SRC_WALL
        |-> o_out_data.texture_id == rcta_pkg::TEX_ID_Y_NEG
            || o_out_data.texture_id == rcta_pkg::TEX_ID_X_POS
            || o_out_data.texture_id == rcta_pkg::TEX_ID_X_NEG
            || o_out_data.texture_id == rcta_pkg::TEX_ID_Y_POS)
        else $error("wall beat with a bad texture slot");

    // fill color only on floor beats
    a_fill_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.pixel_source != rcta_pkg::SRC_FLOOR
        |-> o_out_data.fill_color == '0)
        else $error("fill color on a non-floor beat");
`endif

endmodule
